>>> hw/rtl/fmp_pkg.sv
package fmp_pkg;

	// default index width
	localparam int INDEX_WIDTH_DEF = 31;

	// width of a residue and of the wide intermediate sums
	localparam int VAL_W  = 30;
	localparam int WIDE_W = VAL_W + 2;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [WIDE_W-1:0] wide_t;

	localparam val_t  PRIME      = val_t'(1000000007);
	localparam wide_t PRIME_W    = wide_t'(1000000007);
	localparam wide_t PRIME_X2_W = wide_t'(2000000014);

	// one multiplier bit per cycle
	localparam int MUL_STEPS = VAL_W;
	localparam int CNT_W     = $clog2(MUL_STEPS);

	// control from the sequencer to every multiplier lane
	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	// (p + q) mod prime, both operands already reduced
	function automatic val_t mod_add(input val_t p, input val_t q);
		wide_t s;
		s = wide_t'(p) + wide_t'(q);
		if (s >= PRIME_W) begin
			s = s - PRIME_W;
		end
		return s[VAL_W-1:0];
	endfunction

	// (p - q) mod prime, both operands already reduced
	function automatic val_t mod_sub(input val_t p, input val_t q);
		wide_t s;
		s = wide_t'(p) - wide_t'(q);
		if (p < q) begin
			s = s + PRIME_W;
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

>>> hw/rtl/fibonacci_mod_matrix_power.sv
// channel  | ports                 | handshake
// ---------+-----------------------+-----------------------------------------
// request  | index                 | taken at a clock edge with start & !busy
// result   | value                 | valid high one cycle, no back pressure
//
// index 0 or 1: result strobe in the cycle right after the request is taken
// otherwise the states load, run (multiplier steps) and fold repeat for each
// bit of n-1, then the done state strobes the result; the run state steps
// the bit-serial modular multipliers
// arst_n clears the sequencer only; datapath registers are loaded before use
// one request at a time: busy stays high until the cycle after valid
module fibonacci_mod_matrix_power #(
	parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [INDEX_WIDTH-1:0] index,
	output logic                   busy,
	output logic                   valid,
	output fmp_pkg::val_t          value
);

	// every matrix is a power of [[1,1],[1,0]], hence symmetric with
	// bottom-right = top-left - top-right; only (a, b) is kept per matrix
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_RUN  = 5'b00100,
		ST_FOLD = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [INDEX_WIDTH-1:0]    exp_q;      // remaining exponent, lsb first
	logic [fmp_pkg::CNT_W-1:0] cnt_q;      // multiplier step count
	fmp_pkg::val_t             acc_a_q;    // accumulator top-left
	fmp_pkg::val_t             acc_b_q;    // accumulator top-right
	fmp_pkg::val_t             base_a_q;   // running square top-left
	fmp_pkg::val_t             base_b_q;   // running square top-right
	fmp_pkg::val_t             base_c;     // running square bottom-right

	fmp_pkg::lane_ctl_t        lane_ctl;
	fmp_pkg::val_t             lane_x [8];
	fmp_pkg::val_t             lane_y [8];
	fmp_pkg::val_t             lane_p [8];

	logic                      req_take;
	logic                      run_last;

	assign req_take = start && (state_q == ST_IDLE);
	assign run_last = (cnt_q == fmp_pkg::CNT_W'(fmp_pkg::MUL_STEPS - 1));

	assign base_c = fmp_pkg::mod_sub(base_a_q, base_b_q);

	// lanes 0..3 square the base, lanes 4..7 multiply the accumulator by it
	// top-left  = x.a*y.a + x.b*y.b
	// top-right = x.a*y.b + x.b*y.c
	always_comb begin
		lane_x[0] = base_a_q;  lane_y[0] = base_a_q;
		lane_x[1] = base_b_q;  lane_y[1] = base_b_q;
		lane_x[2] = base_a_q;  lane_y[2] = base_b_q;
		lane_x[3] = base_b_q;  lane_y[3] = base_c;
		lane_x[4] = acc_a_q;   lane_y[4] = base_a_q;
		lane_x[5] = acc_b_q;   lane_y[5] = base_b_q;
		lane_x[6] = acc_a_q;   lane_y[6] = base_b_q;
		lane_x[7] = acc_b_q;   lane_y[7] = base_c;
	end

	assign lane_ctl.load = (state_q == ST_LOAD);
	assign lane_ctl.step = (state_q == ST_RUN);

	for (genvar g = 0; g < 8; g++) begin : g_lane
		fmp_mul_lane u_lane (
			.clk  (clk),
			.ctl  (lane_ctl),
			.x    (lane_x[g]),
			.y    (lane_y[g]),
			.prod (lane_p[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						// index 0 or 1 is its own answer
						state_q <= (index <= INDEX_WIDTH'(1)) ? ST_DONE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + fmp_pkg::CNT_W'(1);
					if (run_last) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					// stop once the last set exponent bit has been used
					state_q <= ((exp_q >> 1) == '0) ? ST_DONE : ST_LOAD;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// matrix registers and exponent
	always_ff @(posedge clk) begin
		if (req_take) begin
			exp_q    <= index - INDEX_WIDTH'(1);
			// identity in the accumulator, or the answer itself for 0 and 1
			acc_a_q  <= (index <= INDEX_WIDTH'(1)) ? fmp_pkg::val_t'(index)
				: fmp_pkg::val_t'(1);
			acc_b_q  <= '0;
			base_a_q <= fmp_pkg::val_t'(1);
			base_b_q <= fmp_pkg::val_t'(1);
		end else if (state_q == ST_FOLD) begin
			exp_q    <= exp_q >> 1;
			base_a_q <= fmp_pkg::mod_add(lane_p[0], lane_p[1]);
			base_b_q <= fmp_pkg::mod_add(lane_p[2], lane_p[3]);
			if (exp_q[0]) begin
				acc_a_q <= fmp_pkg::mod_add(lane_p[4], lane_p[5]);
				acc_b_q <= fmp_pkg::mod_add(lane_p[6], lane_p[7]);
			end
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign valid = (state_q == ST_DONE);
	assign value = acc_a_q;

endmodule

>>> hw/rtl/fmp_mul_lane.sv
// bit-serial modular multiplier, multiplier bits taken msb first
module fmp_mul_lane (
	input  logic                clk,
	input  fmp_pkg::lane_ctl_t  ctl,
	input  fmp_pkg::val_t       x,
	input  fmp_pkg::val_t       y,
	output fmp_pkg::val_t       prod
);

	fmp_pkg::val_t  x_q;
	fmp_pkg::val_t  y_q;
	fmp_pkg::val_t  r_q;
	fmp_pkg::wide_t sum;
	fmp_pkg::wide_t r_next;

	// 2r + x*bit stays below three times the prime
	always_comb begin
		sum = {1'b0, r_q, 1'b0}
			+ (y_q[fmp_pkg::VAL_W-1] ? fmp_pkg::wide_t'(x_q) : '0);
		if (sum >= fmp_pkg::PRIME_X2_W) begin
			r_next = sum - fmp_pkg::PRIME_X2_W;
		end else if (sum >= fmp_pkg::PRIME_W) begin
			r_next = sum - fmp_pkg::PRIME_W;
		end else begin
			r_next = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (ctl.step) begin
			r_q <= r_next[fmp_pkg::VAL_W-1:0];
			y_q <= {y_q[fmp_pkg::VAL_W-2:0], 1'b0};
		end
	end

	assign prod = r_q;

endmodule

>>> hw/rtl/fmp_checker.sv
module fmp_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   valid,
	input fmp_pkg::val_t          value
);

	// a taken request keeps the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// result strobe only while a request is open
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("result outside an open request");

	// one result per request, one cycle wide
	a_valid_once: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid && !busy)
		else $error("result strobe repeated or block stays busy");

	// a request closes only with its result
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(valid))
		else $error("request closed without a result");

	// result is a reduced residue
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> value < fmp_pkg::PRIME)
		else $error("result not reduced");

endmodule

bind fibonacci_mod_matrix_power fmp_checker u_fmp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.value  (value)
);

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = fmp_pkg::INDEX_WIDTH_DEF;

	// modulus of the sequence, kept wide for the 64-bit products
	localparam logic [63:0] FIB_MOD = 64'd1000000007;

	// 2x2 matrix of residues
	typedef struct packed {
		logic [63:0] m00;
		logic [63:0] m01;
		logic [63:0] m10;
		logic [63:0] m11;
	} mat2_t;

	// a request still waiting for its result
	typedef struct packed {
		logic [IDX_W-1:0] index;
		fmp_pkg::val_t    value;
	} fib_request_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	logic [IDX_W-1:0] index  = '0;
	logic             busy;
	logic             valid;
	fmp_pkg::val_t    value;

	fib_request_t pending_fib[$];
	int           mismatches = 0;

	fibonacci_mod_matrix_power #(
		.INDEX_WIDTH(IDX_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.index  (index),
		.busy   (busy),
		.valid  (valid),
		.value  (value)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// expected value: F(n) mod prime by matrix power, low bits first
	// ---------------------------------------------------------------

	// (a*b + c*d) mod prime, every operand already below the prime
	function automatic logic [63:0] mod_dot(input logic [63:0] a, input logic [63:0] b,
	                                        input logic [63:0] c, input logic [63:0] d);
		return ((a * b) % FIB_MOD + (c * d) % FIB_MOD) % FIB_MOD;
	endfunction

	function automatic mat2_t mat_product(input mat2_t x, input mat2_t y);
		mat2_t r;
		r.m00 = mod_dot(x.m00, y.m00, x.m01, y.m10);
		r.m01 = mod_dot(x.m00, y.m01, x.m01, y.m11);
		r.m10 = mod_dot(x.m10, y.m00, x.m11, y.m10);
		r.m11 = mod_dot(x.m10, y.m01, x.m11, y.m11);
		return r;
	endfunction

	function automatic fmp_pkg::val_t fib_mod_prime(input logic [IDX_W-1:0] n);
		mat2_t       acc;
		mat2_t       base;
		logic [63:0] k;
		// indices zero and one come back unchanged
		if (n < 2) begin
			return fmp_pkg::val_t'(n);
		end
		acc.m00  = 64'd1;
		acc.m01  = 64'd0;
		acc.m10  = 64'd0;
		acc.m11  = 64'd1;
		base.m00 = 64'd1;
		base.m01 = 64'd1;
		base.m10 = 64'd1;
		base.m11 = 64'd0;
		k = 64'(n) - 64'd1;
		while (k != 0) begin
			if (k[0]) begin
				acc = mat_product(acc, base);
			end
			k    = k >> 1;
			base = mat_product(base, base);
		end
		return fmp_pkg::val_t'(acc.m00);
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// start stays high after a request so the next one can follow at once;
	// the request is taken at the first edge that sees busy low
	task automatic send_request(input logic [IDX_W-1:0] n);
		fib_request_t req;
		start <= 1'b1;
		index <= n;
		do begin
			@(posedge clk);
		end while (busy);
		req.index = n;
		req.value = fib_mod_prime(n);
		pending_fib.push_back(req);
	endtask

	// sender idle for a number of cycles
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// random idle burst before some of the requests
	task automatic maybe_hold_off();
		if ($urandom_range(0, 2) == 0) begin
			hold_off($urandom_range(1, 15));
		end
	endtask

	// sender idle until every result is back; waits on the clock even when none is pending
	task automatic drain_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_fib.size() != 0);
	endtask

	// mostly short exponents, since the latency grows with each bit,
	// with a few full-width ones
	function automatic logic [IDX_W-1:0] random_index();
		int bits;
		if ($urandom_range(0, 9) == 0) begin
			return IDX_W'($urandom);
		end
		bits = $urandom_range(0, 20);
		return IDX_W'($urandom & ((32'd1 << bits) - 32'd1));
	endfunction

	// ---------------------------------------------------------------
	// result side: no back pressure, every strobe is a result
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		fib_request_t req;
		if (arst_n && valid) begin
			if (pending_fib.size() == 0) begin
				$error("unexpected result: value %0d with no request outstanding", value);
				mismatches++;
			end else begin
				req = pending_fib.pop_front();
				if (value !== req.value) begin
					$error("value mismatch for index %0d: expected %0d, actual %0d",
					       req.index, req.value, value);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// zero and one pass straight through, then the first few terms
	task automatic test_small_indices();
		for (int n = 0; n < 6; n++) begin
			send_request(IDX_W'(n));
			maybe_hold_off();
		end
		// wait for everything before going on
		drain_results();
	endtask

	// full-width and patterned indices, terms around the 64-bit overflow
	// point and around the prime itself
	task automatic test_extreme_indices();
		logic [IDX_W-1:0] corner[$];
		corner = '{
			{IDX_W{1'b1}},
			{{(IDX_W-1){1'b1}}, 1'b0},
			IDX_W'(1) << (IDX_W - 1),
			(IDX_W'(1) << (IDX_W - 1)) + IDX_W'(1),
			IDX_W'(32'h5555_5555),
			IDX_W'(32'h2AAA_AAAA),
			IDX_W'(64),
			IDX_W'(65),
			IDX_W'(92),
			IDX_W'(93),
			IDX_W'(1000000007),
			IDX_W'(1000000008),
			IDX_W'(1000000006)
		};
		foreach (corner[i]) begin
			send_request(corner[i]);
			maybe_hold_off();
		end
	endtask

	// random indices with idle bursts, draining now and then
	task automatic test_random_indices(input int count);
		for (int i = 0; i < count; i++) begin
			send_request(random_index());
			maybe_hold_off();
			if (i % 250 == 249) begin
				drain_results();
			end
		end
	endtask

	// requests back to back with the sender never idle
	task automatic test_back_to_back(input int count);
		for (int i = 0; i < count; i++) begin
			send_request(random_index());
		end
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_indices();
		test_extreme_indices();
		test_random_indices(800);
		test_back_to_back(200);

		// all requests taken: let the last results come back
		drain_results();
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
